FILE: rtl/core/pcs_pkg.sv
// shared constants, types and register codes of the puct child selector
`default_nettype none

package pcs_pkg;

    // sizing of the selection
    localparam int MAX_CHILDREN = 256;
    localparam int VISIT_BITS   = 24;

    // fixed field widths
    localparam int VISIT_IN_W = 24;
    localparam int VSUM_W     = 32;
    localparam int PRIOR_W    = 17;
    localparam int IDX_W      = 8;
    localparam int SCORE_W    = 32;
    localparam int WGT_W      = 16;

    localparam logic [WGT_W-1:0] WGT_RESET = 16'd8192;

    // visit counts are masked to the narrower of the two
    localparam int VIS_W = (VISIT_BITS < VISIT_IN_W) ? VISIT_BITS : VISIT_IN_W;
    localparam int CNT_W = $clog2(MAX_CHILDREN + 1);

    // q16.16 helpers
    localparam int Q16_BITS = 16;
    localparam int ONE_Q16  = 65536;
    localparam int Q_W      = 17;
    localparam int QDIFF_W  = Q_W + 1;

    // square root of parent visits in q.8, one result bit per step
    localparam int SQRT_STEPS = (VIS_W + Q16_BITS + 1) / 2;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int STEP_W     = (SQRT_STEPS > 1) ? $clog2(SQRT_STEPS) : 1;

    // exploration product and its divide by visits plus one
    localparam int WP_W      = WGT_W + PRIOR_W;
    localparam int NUM_W     = WP_W + ROOT_W;
    localparam int U_SHIFT   = 20;
    localparam int DIV_N     = (NUM_W - U_SHIFT > VSUM_W) ? (NUM_W - U_SHIFT) : VSUM_W;
    localparam int DIV_D     = VIS_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WGT = 1'b0;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [RAD_W-1:0]   t_rad;
    typedef logic [DIV_N-1:0]   t_dividend;
    typedef logic [DIV_D-1:0]   t_divisor;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: rtl/core/pcs_if.sv
// valid/ready channel interfaces for child words and result words
`default_nettype none

interface pcs_in_if;
    logic                                valid;
    logic                                ready;
    logic [pcs_pkg::VISIT_IN_W-1:0]      parent_visits;
    logic [pcs_pkg::VISIT_IN_W-1:0]      child_visits;
    logic signed [pcs_pkg::VSUM_W-1:0]   child_value_sum;
    logic [pcs_pkg::PRIOR_W-1:0]         child_prior;
    logic                                is_last;

    modport source (
        output valid, parent_visits, child_visits, child_value_sum, child_prior, is_last,
        input  ready
    );
    modport sink (
        input  valid, parent_visits, child_visits, child_value_sum, child_prior, is_last,
        output ready
    );
endinterface

interface pcs_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcs_pkg::IDX_W-1:0]   best_index;
    logic [pcs_pkg::SCORE_W-1:0] best_score;

    modport source (
        output valid, best_index, best_score,
        input  ready
    );
    modport sink (
        input  valid, best_index, best_score,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/puct_child_selector.sv
// puct child selector: scores tree children one word at a time, reports the best
`default_nettype none

//  port    dir  handshake              word
//  i_in    in   valid/ready            one child's visits, value sum, prior, last flag
//  o_out   out  valid/ready            index and saturated score of the best child
//  apb     in   psel/penable/pwrite    explore weight, q4.12, byte address 0
//
// steps per child: take the word, run the bit-serial root of parent visits,
//   which feeds a shift-add multiply in the same steps, load the divider, run the
//   bit-serial divide by visits plus one, compare; the mean divide runs alongside
// a last child then passes through the finish state to load the result register
// a child past the limit is not scored
// reset: synchronous, active low; weight returns to 2.0 and the running best clears
// stalls: i_in is ready only between children; a new child is taken while a result
//   waits, and the last child of a selection holds until o_out is free

module puct_child_selector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pcs_in_if.sink                             i_in,
    pcs_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pcs_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcs_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROOT   = 3'd1;
    localparam logic [2:0] ST_USTART = 3'd2;
    localparam logic [2:0] ST_UDIV   = 3'd3;
    localparam logic [2:0] ST_CMP    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // control state
    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [pcs_pkg::WGT_W-1:0]    r_wgt;
    logic [pcs_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_have;
    pcs_pkg::t_score              r_best_score;
    pcs_pkg::t_idx                r_best_idx;
    logic                         r_out_valid;
    pcs_pkg::t_idx                r_out_idx;
    pcs_pkg::t_score              r_out_score;

    // per-child working registers
    logic                         r_last;
    logic                         r_neg;
    logic [pcs_pkg::VIS_W-1:0]    r_cv;
    pcs_pkg::t_rad                r_x;
    logic [pcs_pkg::SREM_W-1:0]   r_srem;
    logic [pcs_pkg::ROOT_W-1:0]   r_root;
    logic [pcs_pkg::NUM_W-1:0]    r_acc;
    logic [pcs_pkg::WP_W-1:0]     r_wp;
    logic [pcs_pkg::STEP_W-1:0]   r_step;
    logic [pcs_pkg::Q_W-1:0]      r_q;
    pcs_pkg::t_score              r_score;

    logic                         w_in_acc;
    logic                         w_scored;
    logic                         w_out_free;
    logic                         w_cfg_wr;
    logic [pcs_pkg::VIS_W-1:0]    w_pv;
    logic [pcs_pkg::VIS_W-1:0]    w_cv;
    logic                         w_neg;
    logic [pcs_pkg::VSUM_W-1:0]   w_mag;

    logic [pcs_pkg::SREM_W-1:0]   w_sshift;
    logic [pcs_pkg::SREM_W:0]     w_sdiff;
    logic                         w_sbit;

    pcs_pkg::t_div_stat           w_mstat;
    pcs_pkg::t_div_stat           w_ustat;
    pcs_pkg::t_dividend           w_mquot;
    pcs_pkg::t_dividend           w_uquot;
    logic [pcs_pkg::Q_W-1:0]      w_mean;
    logic [pcs_pkg::QDIFF_W-1:0]  w_qdiff;
    logic [pcs_pkg::Q_W-1:0]      w_q;
    logic [pcs_pkg::DIV_N:0]      w_sum;
    pcs_pkg::t_score              w_sat;

    // handshakes
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_scored   = (r_cnt < pcs_pkg::CNT_W'(pcs_pkg::MAX_CHILDREN));

    assign o_out.valid      = r_out_valid;
    assign o_out.best_index = r_out_idx;
    assign o_out.best_score = r_out_score;

    // register port, address bit 2 picks the register, low address bits are unused
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pcs_pkg::REG_WGT) ? pcs_pkg::PDATA_W'(r_wgt) : '0;

    // input fields, visits masked, magnitude of the value sum
    assign w_pv  = i_in.parent_visits[pcs_pkg::VIS_W-1:0];
    assign w_cv  = i_in.child_visits[pcs_pkg::VIS_W-1:0];
    assign w_neg = i_in.child_value_sum[pcs_pkg::VSUM_W-1];
    assign w_mag = w_neg ? (~i_in.child_value_sum + 1'b1) : i_in.child_value_sum;

    // mean = |value sum| / child visits, started with the child
    pcs_div u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && w_scored),
        .i_dividend (pcs_pkg::DIV_N'(w_mag)),
        .i_divisor  (pcs_pkg::DIV_D'(w_cv)),
        .o_stat     (w_mstat),
        .o_quot     (w_mquot)
    );

    // u = (weight * prior * root) >> 20, divided by visits plus one
    pcs_div u_expl_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_USTART),
        .i_dividend (pcs_pkg::DIV_N'(r_acc[pcs_pkg::NUM_W-1:pcs_pkg::U_SHIFT])),
        .i_divisor  (pcs_pkg::DIV_D'(r_cv) + 1'b1),
        .o_stat     (w_ustat),
        .o_quot     (w_uquot)
    );

    // one root bit per step: bring down two radicand bits, try (root << 2) | 1
    assign w_sshift = {r_srem[pcs_pkg::SREM_W-3:0], r_x[pcs_pkg::RAD_W-1 -: 2]};
    assign w_sdiff  = {1'b0, w_sshift} - (pcs_pkg::SREM_W + 1)'({r_root, 2'b01});
    assign w_sbit   = ~w_sdiff[pcs_pkg::SREM_W];

    // exploitation term, zero for an unvisited child
    assign w_mean  = (w_mquot > pcs_pkg::DIV_N'(pcs_pkg::ONE_Q16))
                   ? pcs_pkg::Q_W'(pcs_pkg::ONE_Q16)
                   : w_mquot[pcs_pkg::Q_W-1:0];
    assign w_qdiff = r_neg ? (pcs_pkg::QDIFF_W'(pcs_pkg::ONE_Q16) + pcs_pkg::QDIFF_W'(w_mean))
                           : (pcs_pkg::QDIFF_W'(pcs_pkg::ONE_Q16) - pcs_pkg::QDIFF_W'(w_mean));
    assign w_q     = (r_cv == '0) ? '0 : w_qdiff[pcs_pkg::QDIFF_W-1:1];

    // score, saturated to 32 bits
    assign w_sum = (pcs_pkg::DIV_N + 1)'(w_uquot) + (pcs_pkg::DIV_N + 1)'(r_q);
    assign w_sat = (|w_sum[pcs_pkg::DIV_N:pcs_pkg::SCORE_W]) ? '1
                                                           : w_sum[pcs_pkg::SCORE_W-1:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_scored) begin
                        n_state = ST_ROOT;
                    end else if (i_in.is_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_ROOT: begin
                if (r_step == '0) begin
                    n_state = ST_USTART;
                end
            end
            ST_USTART: n_state = ST_UDIV;
            ST_UDIV: begin
                if (w_ustat.done) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = r_last ? ST_FIN : ST_IDLE;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers, running best and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wgt        <= pcs_pkg::WGT_RESET;
            r_cnt        <= '0;
            r_have       <= 1'b0;
            r_best_score <= '0;
            r_best_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr && paddr[2] == pcs_pkg::REG_WGT) begin
                r_wgt <= pwdata[pcs_pkg::WGT_W-1:0];
            end
            // a new result word takes the slot, else a taken word frees it
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_CMP) begin
                // strict greater, so a tie keeps the earlier child
                if (!r_have || r_score > r_best_score) begin
                    r_best_score <= r_score;
                    r_best_idx   <= pcs_pkg::t_idx'(r_cnt);
                    r_have       <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_cnt        <= '0;
                r_have       <= 1'b0;
                r_best_score <= '0;
                r_best_idx   <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_idx   <= r_best_idx;
            r_out_score <= r_best_score;
        end
        if (w_in_acc) begin
            r_last <= i_in.is_last;
            r_neg  <= w_neg;
            r_cv   <= w_cv;
            r_x    <= pcs_pkg::t_rad'({w_pv, {pcs_pkg::Q16_BITS{1'b0}}});
            r_srem <= '0;
            r_root <= '0;
            r_acc  <= '0;
            r_wp   <= pcs_pkg::WP_W'(r_wgt) * pcs_pkg::WP_W'(i_in.child_prior);
            r_step <= pcs_pkg::STEP_W'(pcs_pkg::SQRT_STEPS - 1);
        end else if (r_state == ST_ROOT) begin
            // root bits arrive msb first, so the product accumulates msb first
            r_x    <= r_x << 2;
            r_srem <= w_sbit ? w_sdiff[pcs_pkg::SREM_W-1:0] : w_sshift;
            r_root <= {r_root[pcs_pkg::ROOT_W-2:0], w_sbit};
            r_acc  <= (r_acc << 1) + (w_sbit ? pcs_pkg::NUM_W'(r_wp) : '0);
            r_step <= r_step - 1'b1;
        end
        if (w_mstat.done) begin
            r_q <= w_q;
        end
        if (r_state == ST_UDIV && w_ustat.done) begin
            r_score <= w_sat;
        end
    end

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pcs_pkg::CNT_W'(pcs_pkg::MAX_CHILDREN))
        else $error("child counter beyond limit");

    a_udone_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ustat.done |-> r_state == ST_UDIV)
        else $error("exploration divide finished outside its wait state");

    a_mean_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ustat.done |-> !w_mstat.busy)
        else $error("mean divide still running when the score is formed");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result word raised outside the finish state");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_cnt == '0)
        else $error("children counted with no candidate held");

endmodule

`default_nettype wire

FILE: rtl/core/pcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module pcs_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire pcs_pkg::t_dividend i_dividend,
    input  wire pcs_pkg::t_divisor  i_divisor,
    output pcs_pkg::t_div_stat      o_stat,
    output pcs_pkg::t_dividend      o_quot
);

    logic [pcs_pkg::DIV_N-1:0]     r_num;
    logic [pcs_pkg::DIV_D-1:0]     r_rem;
    logic [pcs_pkg::DIV_D-1:0]     r_den;
    logic [pcs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;

    logic [pcs_pkg::DIV_D:0]       w_shift;
    logic [pcs_pkg::DIV_D+1:0]     w_diff;
    logic                          w_borrow;

    assign w_shift  = {r_rem, r_num[pcs_pkg::DIV_N-1]};
    assign w_diff   = {1'b0, w_shift} - {2'b00, r_den};
    assign w_borrow = w_diff[pcs_pkg::DIV_D+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_cnt  <= pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_N);
                r_done <= 1'b0;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == pcs_pkg::DIV_CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // quotient bits shift in where the dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[pcs_pkg::DIV_N-2:0], ~w_borrow};
            r_rem <= w_borrow ? w_shift[pcs_pkg::DIV_D-1:0] : w_diff[pcs_pkg::DIV_D-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

`default_nettype wire
